FILE: rtl/wfsa_pkg.sv
// ----------------------------------------------------------------------------
// wfsa_pkg: shared types and codes for the worst-fit segment allocator
// Status codes, request kinds and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package wfsa_pkg;

  // address width of the managed region; port fields are sized for 16
  localparam int ADDR_BITS = 16;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD      = 3'd4
  } status_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHUP,
    S_SPLIT,
    S_FREE,
    S_MNEXT,
    S_MPREV,
    S_SHDN,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/worst_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// worst_fit_segment_allocator: worst-fit allocate / free over a segment table
// Address-ordered segment table in one synchronous memory, read-modify-write
// by a small sequencer.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tuser=func, tdata=req_size,owner_id
// m_axis    out  tvalid/tready           tdata=status,seg_base,seg_length
// cfg       in   region_size_we          region_size_wdata
//
// One request at a time; a request runs from accept to m_axis_tvalid as one
// scan pass over the memory (one read a cycle, data in the cycle after)
// plus up to two shift passes (split, or merge with next and previous).
// A rejected request skips the scan and goes straight to the result.
// Reset, or a region_size write, leaves one free segment; no clearing pass.
// A held result blocks the next request until m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none
module worst_fit_segment_allocator
  import wfsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16,
  parameter int ID_BITS      = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [16:0] req_size, [24:17] owner_id
  input  wire logic        s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [2:0] status, [18:3] seg_base, [35:19] seg_length
  input  wire logic        region_size_we,
  input  wire logic [16:0] region_size_wdata
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int LW = ADDR_BITS + 1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] last;
    logic [ID_BITS-1:0]   owner;
  } seg_t;

  // segment table memory
  seg_t              mem [MAX_SEGMENTS];
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  seg_t              mem_wdata;
  logic [IW-1:0]     mem_raddr;
  seg_t              rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd <= mem[mem_raddr];
  end

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [LW-1:0]     region;
  logic              cfg_pend;
  logic              req_func;
  logic [LW-1:0]     req_size;
  logic [ID_BITS-1:0] req_id;
  logic [CW-1:0]     ptr, ptr_next;    // read pointer
  logic [CW-1:0]     rptr, rptr_next;  // index of data in rd
  logic              rvalid, rvalid_next;
  logic              found, found_next;
  logic [IW-1:0]     best, best_next;
  logic [LW-1:0]     best_len, best_len_next;
  seg_t              bseg, bseg_next;  // chosen entry
  seg_t              pseg, pseg_next;  // previous entry during free scan
  logic [2:0]        ost, ost_next;
  logic [ADDR_BITS-1:0] obase, obase_next;
  logic [LW-1:0]     olen, olen_next;
  logic              ovalid;
  logic              merge_prev, merge_prev_next;
  logic [IW-1:0]     drop, drop_next; // index removed by shift-down

  logic [LW-1:0]     rd_len;

  assign rd_len  = LW'({1'b0, rd.last} - {1'b0, rd.start} + 1'b1);

  assign s_axis_tready = (state == S_IDLE) && !ovalid && !cfg_pend;
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {4'd0, 17'(olen), 16'(obase), ost};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= CW'(1);
      region   <= LW'(65536 > (1 << ADDR_BITS) ? (1 << ADDR_BITS) : 65536);
      cfg_pend <= 1'b1;
      ovalid   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (region_size_we) begin
        cfg_pend <= 1'b1;
        if (region_size_wdata == '0) begin
          region <= LW'(1);
        end else if (18'(region_size_wdata) > 18'(1 << ADDR_BITS)) begin
          region <= LW'(1 << ADDR_BITS);
        end else begin
          region <= LW'(region_size_wdata);
        end
      end else if (cfg_pend) begin
        cfg_pend <= 1'b0;
        count    <= CW'(1);
      end
      if (state == S_OUT) begin
        ovalid <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_func <= s_axis_tuser;
      req_size <= LW'(s_axis_tdata[16:0]);
      req_id   <= ID_BITS'(s_axis_tdata[24:17]);
    end
    ptr <= ptr_next;
    rptr <= rptr_next;
    rvalid <= rvalid_next;
    found <= found_next;
    best <= best_next;
    best_len <= best_len_next;
    bseg <= bseg_next;
    pseg <= pseg_next;
    ost <= ost_next;
    obase <= obase_next;
    olen <= olen_next;
    merge_prev <= merge_prev_next;
    drop <= drop_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next = ptr;
    rptr_next = rptr;
    rvalid_next = 1'b0;
    found_next = found;
    best_next = best;
    best_len_next = best_len;
    bseg_next = bseg;
    pseg_next = pseg;
    ost_next = ost;
    obase_next = obase;
    olen_next = olen;
    merge_prev_next = merge_prev;
    drop_next = drop;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = ptr[IW-1:0];
    // config rewrites entry 0
    if (cfg_pend && state == S_IDLE && !region_size_we) begin
      mem_we = 1'b1;
      mem_waddr = '0;
      mem_wdata.start = '0;
      mem_wdata.last = ADDR_BITS'(region - 1'b1);
      mem_wdata.owner = '0;
    end
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ptr_next = '0;
          found_next = 1'b0;
          best_len_next = '0;
          merge_prev_next = 1'b0;
          if (ID_BITS'(s_axis_tdata[24:17]) == '0 ||
              (s_axis_tuser == FUNC_ALLOC && s_axis_tdata[16:0] == '0)) begin
            ost_next = ST_BAD;
            obase_next = '0;
            olen_next = '0;
            state_next = S_OUT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue reads, consume rd in the following cycle
        if (ptr < count) begin
          mem_raddr = ptr[IW-1:0];
          rvalid_next = 1'b1;
          rptr_next = ptr;
          ptr_next = ptr + 1'b1;
        end
        if (rvalid) begin
          pseg_next = rd;
          if (req_func == FUNC_ALLOC) begin
            if (rd.owner == '0 && req_size <= rd_len && rd_len > best_len) begin
              found_next = 1'b1;
              best_next = rptr[IW-1:0];
              best_len_next = rd_len;
              bseg_next = rd;
            end
          end else if (rd.owner == req_id) begin
            found_next = 1'b1;
            best_next = rptr[IW-1:0];
            bseg_next = rd;
            // keep the entry below the hit for a merge with previous
            pseg_next = pseg;
            merge_prev_next = (rptr != '0) && (pseg.owner == '0);
            rvalid_next = 1'b0;
            state_next = S_DECIDE;
          end
        end
        if (ptr >= count && !rvalid && state_next == S_SCAN) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_OUT;
        obase_next = '0;
        olen_next = '0;
        if (!found) begin
          ost_next = (req_func == FUNC_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
        end else if (req_func == FUNC_ALLOC) begin
          ost_next = ST_OK;
          obase_next = bseg.start;
          olen_next = req_size;
          if (req_size == best_len) begin
            mem_we = 1'b1;
            mem_waddr = best;
            mem_wdata = bseg;
            mem_wdata.owner = req_id;
          end else if (count >= CW'(MAX_SEGMENTS)) begin
            ost_next = ST_FULL;
            obase_next = '0;
            olen_next = '0;
          end else begin
            // shift entries best+1..count-1 up by one, top first
            ptr_next = count - 1'b1;
            state_next = S_SHUP;
            mem_raddr = IW'(count - 1'b1);
          end
        end else begin
          ost_next = ST_OK;
          obase_next = bseg.start;
          olen_next = LW'({1'b0, bseg.last} - {1'b0, bseg.start} + 1'b1);
          ptr_next = CW'(best) + 1'b1;
          state_next = S_FREE;
        end
      end
      S_SHUP: begin
        // rd holds entry ptr (read last cycle)
        if (ptr > CW'(best)) begin
          mem_we = 1'b1;
          mem_waddr = IW'(ptr + 1'b1);
          mem_wdata = rd;
          ptr_next = ptr - 1'b1;
          mem_raddr = IW'(ptr - 1'b1);
        end else begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        // upper free remainder
        mem_we = 1'b1;
        mem_waddr = best + 1'b1;
        mem_wdata.start = ADDR_BITS'(bseg.start + req_size);
        mem_wdata.last = bseg.last;
        mem_wdata.owner = '0;
        bseg_next.last = ADDR_BITS'(bseg.start + req_size - 1'b1);
        bseg_next.owner = req_id;
        count_next = count + 1'b1;
        ptr_next = CW'(best);
        state_next = S_MPREV; // reuse: writes bseg at best
        merge_prev_next = 1'b0;
      end
      S_FREE: begin
        // read next entry
        mem_raddr = ptr[IW-1:0];
        bseg_next.owner = '0;
        state_next = S_MNEXT;
      end
      S_MNEXT: begin
        drop_next = best + 1'b1;
        ptr_next = CW'(best) + 2'd2;
        if (CW'(best) + 1'b1 < count && rd.owner == '0) begin
          bseg_next.last = rd.last;
          state_next = S_SHDN;
          mem_raddr = IW'(CW'(best) + 2'd2);
        end else begin
          state_next = S_MPREV;
        end
      end
      S_MPREV: begin
        if (merge_prev) begin
          // fold into previous entry and drop this one
          mem_we = 1'b1;
          mem_waddr = best - 1'b1;
          mem_wdata = pseg;
          mem_wdata.last = bseg.last;
          merge_prev_next = 1'b0;
          drop_next = best;
          ptr_next = CW'(best) + 1'b1;
          mem_raddr = IW'(CW'(best) + 1'b1);
          state_next = S_SHDN;
        end else begin
          mem_we = 1'b1;
          mem_waddr = best;
          mem_wdata = bseg;
          state_next = S_OUT;
        end
      end
      S_SHDN: begin
        // rd holds entry ptr; move it to ptr-1
        if (ptr < count) begin
          mem_we = 1'b1;
          mem_waddr = IW'(ptr - 1'b1);
          mem_wdata = rd;
          ptr_next = ptr + 1'b1;
          mem_raddr = IW'(ptr + 1'b1);
        end else begin
          count_next = count - 1'b1;
          // entry best itself was dropped: nothing left to write back
          state_next = (drop == best) ? S_OUT : S_MPREV;
        end
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/wfsa_checker.sv
// ----------------------------------------------------------------------------
// wfsa_checker: port-level checks for the worst-fit segment allocator
// Handshake and result-code sanity seen from the ports.
// ----------------------------------------------------------------------------
`default_nettype none
module wfsa_checker
  import wfsa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_BAD)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[35:3] == '0)
    else $error("error result carries data");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == ST_OK |-> m_axis_tdata[35:19] != '0)
    else $error("ok result with zero length");

  a_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

endmodule

bind worst_fit_segment_allocator wfsa_checker u_wfsa_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
